// ===== design/m68kdec_pkg.sv =====
package m68kdec_pkg;

   localparam int WORD_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 16;

   typedef enum logic [5:0] {
      OP_BSET_BTST     = 6'd0,
      OP_ANDI_EORI_ORI = 6'd1,
      OP_MOVE          = 6'd2,
      OP_LEA           = 6'd3,
      OP_EXT           = 6'd4,
      OP_MOVE_FROM_SR  = 6'd5,
      OP_NEG           = 6'd6,
      OP_MOVE_FROM_CCR = 6'd7,
      OP_CLR           = 6'd8,
      OP_MOVE_TO_CCR   = 6'd9,
      OP_MOVE_TO_SR    = 6'd10,
      OP_NOT           = 6'd11,
      OP_PEA           = 6'd12,
      OP_SWAP          = 6'd13,
      OP_MOVEM         = 6'd14,
      OP_LINK          = 6'd15,
      OP_TST           = 6'd16,
      OP_RTS           = 6'd17,
      OP_NOP           = 6'd18,
      OP_JMP           = 6'd19,
      OP_UNLK          = 6'd20,
      OP_MOVE_USP      = 6'd21,
      OP_JSR           = 6'd22,
      OP_SCC           = 6'd23,
      OP_DBCC          = 6'd24,
      OP_ADDQ          = 6'd25,
      OP_BRA           = 6'd26,
      OP_BSR           = 6'd27,
      OP_BCC           = 6'd28,
      OP_MOVEQ         = 6'd29,
      OP_AND_EOR_OR    = 6'd30,
      OP_EMU           = 6'd31,
      OP_EXG           = 6'd32,
      OP_SHIFT_REG     = 6'd33
   } op_type;

   localparam logic [3:0] LINE_BIT_IMM  = 4'h0;
   localparam logic [3:0] LINE_MOVE_B   = 4'h1;
   localparam logic [3:0] LINE_MOVE_L   = 4'h2;
   localparam logic [3:0] LINE_MOVE_W   = 4'h3;
   localparam logic [3:0] LINE_MISC     = 4'h4;
   localparam logic [3:0] LINE_ADDQ_SCC = 4'h5;
   localparam logic [3:0] LINE_BRANCH   = 4'h6;
   localparam logic [3:0] LINE_MOVEQ    = 4'h7;
   localparam logic [3:0] LINE_OR       = 4'h8;
   localparam logic [3:0] LINE_EMU      = 4'hA;
   localparam logic [3:0] LINE_EOR      = 4'hB;
   localparam logic [3:0] LINE_AND_EXG  = 4'hC;
   localparam logic [3:0] LINE_SHIFT    = 4'hE;

   localparam logic [3:0] SUB_0 = 4'h0;
   localparam logic [3:0] SUB_1 = 4'h1;
   localparam logic [3:0] SUB_2 = 4'h2;
   localparam logic [3:0] SUB_4 = 4'h4;
   localparam logic [3:0] SUB_6 = 4'h6;
   localparam logic [3:0] SUB_8 = 4'h8;
   localparam logic [3:0] SUB_A = 4'hA;
   localparam logic [3:0] SUB_C = 4'hC;
   localparam logic [3:0] SUB_E = 4'hE;

   localparam logic [1:0] SZ_BYTE    = 2'd0;
   localparam logic [1:0] SZ_WORD    = 2'd1;
   localparam logic [1:0] SZ_LONG    = 2'd2;
   localparam logic [1:0] SZ_SPECIAL = 2'd3;

   localparam logic [2:0] MODE_DREG    = 3'd0;
   localparam logic [2:0] MODE_AREG    = 3'd1;
   localparam logic [2:0] MODE_IND     = 3'd2;
   localparam logic [2:0] MODE_POSTINC = 3'd3;
   localparam logic [2:0] MODE_PREDEC  = 3'd4;
   localparam logic [2:0] MODE_DISP    = 3'd5;
   localparam logic [2:0] MODE_INDEX   = 3'd6;
   localparam logic [2:0] MODE_OTHER   = 3'd7;

   localparam logic [7:0] LOW_RTS = 8'h75;
   localparam logic [7:0] LOW_NOP = 8'h71;

   // packed lowest field last: operation sits in bits 5..0
   typedef struct packed {
      logic   unimplemented;
      logic   variant_c;
      logic   variant_b;
      logic   variant_a;
      op_type operation;
   } decode_type;

endpackage

// ===== design/m68kdec_decode.sv =====
module m68kdec_decode (
   input  logic [m68kdec_pkg::WORD_WIDTH-1:0] opcode_word,
   output m68kdec_pkg::decode_type            result
);
   import m68kdec_pkg::*;

   logic [3:0] line;
   logic [3:0] sub;
   logic [7:0] lo;
   logic [1:0] sz;
   logic [2:0] mode;
   logic       b0;
   logic       ea_ctl;

   function automatic decode_type mk(input op_type op, input logic a, input logic b,
                                     input logic c);
      decode_type d;
      d.operation     = op;
      d.variant_a     = a;
      d.variant_b     = b;
      d.variant_c     = c;
      d.unimplemented = 1'b0;
      return d;
   endfunction

   function automatic decode_type bad();
      decode_type d;
      d.operation     = OP_BSET_BTST;
      d.variant_a     = 1'b0;
      d.variant_b     = 1'b0;
      d.variant_c     = 1'b0;
      d.unimplemented = 1'b1;
      return d;
   endfunction

   assign line   = opcode_word[15:12];
   assign sub    = opcode_word[11:8];
   assign lo     = opcode_word[7:0];
   assign sz     = opcode_word[7:6];
   assign mode   = opcode_word[5:3];
   assign b0     = opcode_word[8];
   assign ea_ctl = (mode == MODE_IND) || (mode == MODE_DISP) ||
                   (mode == MODE_INDEX) || (mode == MODE_OTHER);

   always_comb begin
      result = bad();
      unique case (line)
         LINE_BIT_IMM: begin
            if ((sz == SZ_BYTE || sz == SZ_SPECIAL) && mode != MODE_AREG) begin
               result = mk(OP_BSET_BTST, sz == SZ_SPECIAL, ~b0, 1'b0);
            end else if (sz == SZ_SPECIAL || mode == MODE_AREG) begin
               result = bad();
            end else if (sub == SUB_0) begin
               result = mk(OP_ANDI_EORI_ORI, 1'b1, 1'b0, 1'b0);
            end else if (sub == SUB_A) begin
               result = mk(OP_ANDI_EORI_ORI, 1'b1, 1'b1, 1'b0);
            end else if (sub == SUB_2) begin
               result = mk(OP_ANDI_EORI_ORI, 1'b0, 1'b0, 1'b0);
            end
         end
         LINE_MOVE_B, LINE_MOVE_L, LINE_MOVE_W: begin
            result = mk(OP_MOVE, 1'b0, 1'b0, 1'b0);
         end
         LINE_MISC: begin
            if (b0 && sz == SZ_SPECIAL) begin
               if (ea_ctl) result = mk(OP_LEA, 1'b0, 1'b0, 1'b0);
               else if (mode == MODE_DREG) result = mk(OP_EXT, 1'b0, 1'b0, 1'b0);
            end else begin
               unique case (sub)
                  SUB_0: begin
                     if (mode != MODE_AREG) begin
                        result = (sz == SZ_SPECIAL) ? mk(OP_MOVE_FROM_SR, 1'b0, 1'b0, 1'b0)
                                                    : mk(OP_NEG, 1'b1, 1'b0, 1'b0);
                     end
                  end
                  SUB_2: begin
                     if (mode != MODE_AREG) begin
                        result = (sz == SZ_SPECIAL) ? mk(OP_MOVE_FROM_CCR, 1'b0, 1'b0, 1'b0)
                                                    : mk(OP_CLR, 1'b0, 1'b0, 1'b0);
                     end
                  end
                  SUB_4: begin
                     if (mode != MODE_AREG) begin
                        result = (sz == SZ_SPECIAL) ? mk(OP_MOVE_TO_CCR, 1'b0, 1'b0, 1'b0)
                                                    : mk(OP_NEG, 1'b0, 1'b0, 1'b0);
                     end
                  end
                  SUB_6: begin
                     if (sz == SZ_SPECIAL) result = mk(OP_MOVE_TO_SR, 1'b0, 1'b0, 1'b0);
                     else if (mode != MODE_AREG) result = mk(OP_NOT, 1'b0, 1'b0, 1'b0);
                  end
                  SUB_8: begin
                     if (sz == SZ_WORD) begin
                        if (ea_ctl) result = mk(OP_PEA, 1'b0, 1'b0, 1'b0);
                        else if (mode == MODE_DREG) result = mk(OP_SWAP, 1'b0, 1'b0, 1'b0);
                     end else if (sz == SZ_LONG || sz == SZ_SPECIAL) begin
                        if (mode == MODE_DREG) begin
                           result = mk(OP_EXT, 1'b0, 1'b0, 1'b0);
                        end else if (mode == MODE_PREDEC || ea_ctl) begin
                           result = mk(OP_MOVEM, 1'b1, 1'b0, 1'b0);
                        end
                     end else if (mode == MODE_AREG) begin
                        result = mk(OP_LINK, 1'b1, 1'b0, 1'b0);
                     end
                  end
                  SUB_A: begin
                     if (sz != SZ_SPECIAL) result = mk(OP_TST, 1'b0, 1'b0, 1'b0);
                  end
                  SUB_C: begin
                     if ((sz == SZ_LONG || sz == SZ_SPECIAL) &&
                         (mode == MODE_POSTINC || ea_ctl)) begin
                        result = mk(OP_MOVEM, 1'b0, 1'b0, 1'b0);
                     end
                  end
                  SUB_E: begin
                     if (lo == LOW_RTS) begin
                        result = mk(OP_RTS, 1'b0, 1'b0, 1'b0);
                     end else if (lo == LOW_NOP) begin
                        result = mk(OP_NOP, 1'b0, 1'b0, 1'b0);
                     end else if (sz == SZ_SPECIAL) begin
                        if (ea_ctl) result = mk(OP_JMP, 1'b0, 1'b0, 1'b0);
                     end else if (sz == SZ_WORD) begin
                        if (mode == MODE_IND) result = mk(OP_LINK, 1'b0, 1'b0, 1'b0);
                        else if (mode == MODE_POSTINC) result = mk(OP_UNLK, 1'b0, 1'b0, 1'b0);
                        else if (mode == MODE_PREDEC) result = mk(OP_MOVE_USP, 1'b1, 1'b0, 1'b0);
                        else if (mode == MODE_DISP) result = mk(OP_MOVE_USP, 1'b0, 1'b0, 1'b0);
                     end else if (sz == SZ_LONG) begin
                        if (ea_ctl) result = mk(OP_JSR, 1'b0, 1'b0, 1'b0);
                     end
                  end
                  default: result = bad();
               endcase
            end
         end
         LINE_ADDQ_SCC: begin
            if (sz == SZ_SPECIAL) begin
               result = (mode != MODE_AREG) ? mk(OP_SCC, 1'b0, 1'b0, 1'b0)
                                            : mk(OP_DBCC, 1'b0, 1'b0, 1'b0);
            end else if (!b0) begin
               result = mk(OP_ADDQ, 1'b0, 1'b0, 1'b0);
            end
         end
         LINE_BRANCH: begin
            if (sub == SUB_0) result = mk(OP_BRA, 1'b0, 1'b0, 1'b0);
            else if (sub == SUB_1) result = mk(OP_BSR, 1'b0, 1'b0, 1'b0);
            else result = mk(OP_BCC, 1'b0, 1'b0, 1'b0);
         end
         LINE_MOVEQ: begin
            if (!b0) result = mk(OP_MOVEQ, 1'b0, 1'b0, 1'b0);
         end
         LINE_OR: begin
            if (mode != MODE_AREG && sz != SZ_SPECIAL) begin
               result = mk(OP_AND_EOR_OR, 1'b1, 1'b0, ~b0);
            end
         end
         LINE_EMU: begin
            result = mk(OP_EMU, 1'b0, 1'b0, 1'b0);
         end
         LINE_EOR: begin
            if (mode != MODE_AREG && sz != SZ_SPECIAL) begin
               result = mk(OP_AND_EOR_OR, 1'b1, 1'b1, 1'b0);
            end
         end
         LINE_AND_EXG: begin
            if (mode == MODE_DREG || mode == MODE_AREG) begin
               if (b0 && (sz == SZ_WORD || sz == SZ_LONG)) begin
                  result = mk(OP_EXG, 1'b0, 1'b0, 1'b0);
               end
            end else if (sz != SZ_SPECIAL) begin
               result = mk(OP_AND_EOR_OR, 1'b0, 1'b0, ~b0);
            end
         end
         LINE_SHIFT: begin
            if (mode == MODE_DREG) result = mk(OP_SHIFT_REG, 1'b0, ~lo[5], 1'b0);
            else if (mode == MODE_PREDEC) result = mk(OP_SHIFT_REG, 1'b1, ~lo[5], 1'b0);
         end
         default: result = bad();
      endcase
   end

endmodule

// ===== design/m68k_opcode_word_decoder.sv =====
// Decodes the first word of a 68000-family instruction into a handler class, three
// variant flags and an unimplemented flag. One word is taken every cycle unless a
// stalled result backs up into a full input register; each word passes an input
// register, the decode tree and a result register. A stalled result holds the result
// register, and the input register once it is full; the input side keeps accepting
// while the input register is empty or can move on.
module m68k_opcode_word_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [m68kdec_pkg::WORD_WIDTH-1:0]     req_tdata,  // opcode_word[15:0]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // operation[5:0], variant_a[6], variant_b[7], variant_c[8], zero fill[15:9]
   output logic [m68kdec_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [0:0]                            rsp_tuser   // unimplemented[0]
);
   import m68kdec_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic                  out_valid_ff, out_valid_in;
   decode_type            result_ff, result_in;
   decode_type            decoded;
   logic                  advance;

   m68kdec_decode u_decode (
      .opcode_word (word_ff),
      .result      (decoded)
   );

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
      word_in      = (req_tvalid && req_tready) ? req_tdata : word_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      result_in    = (advance && in_valid_ff) ? decoded : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      word_ff   <= word_in;
      result_ff <= result_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 9){1'b0}}, result_ff.variant_c,
                        result_ff.variant_b, result_ff.variant_a, result_ff.operation};
   assign rsp_tuser  = result_ff.unimplemented;

endmodule

// ===== design/m68kdec_checker.sv =====
module m68kdec_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [m68kdec_pkg::WORD_WIDTH-1:0]     req_tdata,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [m68kdec_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [0:0]                            rsp_tuser
);
   import m68kdec_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("waiting word changed before its transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused with the result side free");

   a_undecoded_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("undecoded word carries class or variants");

   a_dest_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[5:0] == OP_AND_EOR_OR)
      else $error("destination flag on a class that has none");

endmodule

bind m68k_opcode_word_decoder m68kdec_checker u_m68kdec_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
